@@ hdl/ssrl_pkg.sv @@
// Shared types, codes and constants for the servo slew rate limiter.
`timescale 1ns / 1ps
`default_nettype none

package ssrl_pkg;

    localparam int ANGLE_W   = 16;
    localparam int RATE_W    = 24;
    localparam int EPS_W     = 8;
    localparam int TIME_W    = 32;
    localparam int DEG_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int PROD_W    = RATE_W + TIME_W;
    localparam int SAT_W     = 26;
    localparam int STEP_W    = 17;
    localparam int RECIP_SH  = 36;
    localparam int RECIP_W   = 27;

    // ceil(2^36 / 1000): exact floor division by 1000 for inputs below 2^26
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(68719477);

    typedef enum logic [1:0] {
        REQ_SET_TARGET    = 2'd0,
        REQ_SET_IMMEDIATE = 2'd1,
        REQ_TICK          = 2'd2,
        REQ_RESTART       = 2'd3
    } req_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE     = 3'd0,
        CFG_MAX_ANGLE     = 3'd1,
        CFG_INITIAL_ANGLE = 3'd2,
        CFG_MAX_RATE      = 3'd3,
        CFG_ANGLE_EPSILON = 3'd4
    } cfg_idx_e;

    localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE     = 16'd0;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE     = 16'd46080;
    localparam logic [ANGLE_W-1:0] RST_INITIAL_ANGLE = 16'd23040;
    localparam logic [RATE_W-1:0]  RST_MAX_RATE      = 24'd15360;
    localparam logic [EPS_W-1:0]   RST_ANGLE_EPSILON = 8'd3;

    localparam logic [ANGLE_W-1:0] RST_LO =
        (RST_MIN_ANGLE < RST_MAX_ANGLE) ? RST_MIN_ANGLE : RST_MAX_ANGLE;
    localparam logic [ANGLE_W-1:0] RST_HI =
        (RST_MIN_ANGLE < RST_MAX_ANGLE) ? RST_MAX_ANGLE : RST_MIN_ANGLE;
    localparam logic [ANGLE_W-1:0] RST_POSITION =
        (RST_INITIAL_ANGLE < RST_LO) ? RST_LO :
        (RST_INITIAL_ANGLE > RST_HI) ? RST_HI : RST_INITIAL_ANGLE;

    typedef struct packed {
        logic [ANGLE_W-1:0] min_angle;
        logic [ANGLE_W-1:0] max_angle;
        logic [ANGLE_W-1:0] initial_angle;
        logic [RATE_W-1:0]  max_rate;
        logic [EPS_W-1:0]   angle_epsilon;
    } cfg_t;

    typedef struct packed {
        req_e               req;
        logic [ANGLE_W-1:0] angle;
        logic               first;
        logic [TIME_W-1:0]  elapsed;
    } front_t;

    typedef struct packed {
        req_e               req;
        logic [ANGLE_W-1:0] angle;
        logic               first;
        logic               elapsed_nz;
        logic               big;
        logic [STEP_W-1:0]  step;
    } step_t;

endpackage

`default_nettype wire

@@ hdl/ssrl_if.sv @@
// Channel interfaces: command, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface ssrl_cmd_if
    import ssrl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [ANGLE_W-1:0] angle;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, req_type, angle, now_ms, input ready);
    modport sink   (input valid, req_type, angle, now_ms, output ready);
endinterface

interface ssrl_res_if
    import ssrl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               write_valid;
    logic [DEG_W-1:0]   servo_degrees;
    logic [ANGLE_W-1:0] current_angle;
    logic [ANGLE_W-1:0] target_angle;

    modport source (output valid, write_valid, servo_degrees, current_angle, target_angle,
                    input ready);
    modport sink   (input valid, write_valid, servo_degrees, current_angle, target_angle,
                    output ready);
endinterface

interface ssrl_cfg_if
    import ssrl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/ssrl_cfg.sv @@
// Configuration register bank.
`timescale 1ns / 1ps
`default_nettype none

module ssrl_cfg
    import ssrl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssrl_cfg_if.sink    cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MIN_ANGLE:     regs_next.min_angle     = cfg.data[ANGLE_W-1:0];
                CFG_MAX_ANGLE:     regs_next.max_angle     = cfg.data[ANGLE_W-1:0];
                CFG_INITIAL_ANGLE: regs_next.initial_angle = cfg.data[ANGLE_W-1:0];
                CFG_MAX_RATE:      regs_next.max_rate      = cfg.data[RATE_W-1:0];
                CFG_ANGLE_EPSILON: regs_next.angle_epsilon = cfg.data[EPS_W-1:0];
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.min_angle     <= RST_MIN_ANGLE;
            regs_reg.max_angle     <= RST_MAX_ANGLE;
            regs_reg.initial_angle <= RST_INITIAL_ANGLE;
            regs_reg.max_rate      <= RST_MAX_RATE;
            regs_reg.angle_epsilon <= RST_ANGLE_EPSILON;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ssrl_front.sv @@
// Input register stage: tick time tracking and elapsed time.
`timescale 1ns / 1ps
`default_nettype none

module ssrl_front
    import ssrl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssrl_cmd_if.sink    cmd,
    input  wire logic   down_ready,
    output logic        s1_valid,
    output front_t      s1
);

    logic              valid_reg;
    front_t            s1_reg;
    logic [TIME_W-1:0] last_tick_reg;
    logic [TIME_W-1:0] last_tick_next;
    logic              have_tick_reg;
    logic              have_tick_next;
    logic              en;
    logic              accept;
    req_e              req;

    assign en        = !valid_reg || down_ready;
    assign cmd.ready = en;
    assign accept    = cmd.valid && en;
    assign req       = req_e'(cmd.req_type);
    assign s1_valid  = valid_reg;
    assign s1        = s1_reg;

    always_comb
    begin
        last_tick_next = last_tick_reg;
        have_tick_next = have_tick_reg;
        if (accept)
        begin
            unique case (req)
                REQ_SET_IMMEDIATE, REQ_RESTART:
                    have_tick_next = 1'b0;
                REQ_TICK:
                begin
                    last_tick_next = cmd.now_ms;
                    have_tick_next = 1'b1;
                end
                default:
                    have_tick_next = have_tick_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_tick_reg <= '0;
            have_tick_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= cmd.valid;
            end
            last_tick_reg <= last_tick_next;
            have_tick_reg <= have_tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.req     <= req;
            s1_reg.angle   <= cmd.angle;
            s1_reg.first   <= !have_tick_reg;
            s1_reg.elapsed <= cmd.now_ms - last_tick_reg;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ssrl_step.sv @@
// Step size stages: rate times elapsed, then floor division by 1000.
`timescale 1ns / 1ps
`default_nettype none

module ssrl_step
    import ssrl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [RATE_W-1:0] max_rate,
    input  wire logic          s1_valid,
    input  front_t             s1,
    output logic               up_ready,
    input  wire logic          down_ready,
    output logic               s3_valid,
    output step_t              s3
);

    logic                      v2_reg;
    logic                      v3_reg;
    logic                      en2;
    logic                      en3;
    req_e                      req2_reg;
    logic [ANGLE_W-1:0]        angle2_reg;
    logic                      first2_reg;
    logic                      nz2_reg;
    logic                      big2_reg;
    logic [SAT_W-1:0]          sat2_reg;
    logic [PROD_W-1:0]         prod;
    logic [SAT_W+RECIP_W-1:0]  quot_prod;
    step_t                     s3_reg;

    assign en3      = !v3_reg || down_ready;
    assign en2      = !v2_reg || en3;
    assign up_ready = en2;
    assign s3_valid = v3_reg;
    assign s3       = s3_reg;

    assign prod      = PROD_W'(max_rate) * PROD_W'(s1.elapsed);
    assign quot_prod = (SAT_W+RECIP_W)'(sat2_reg) * (SAT_W+RECIP_W)'(RECIP_1000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= s1_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid)
        begin
            req2_reg   <= s1.req;
            angle2_reg <= s1.angle;
            first2_reg <= s1.first;
            nz2_reg    <= |s1.elapsed;
            big2_reg   <= |prod[PROD_W-1:SAT_W];
            sat2_reg   <= prod[SAT_W-1:0];
        end
        if (en3 && v2_reg)
        begin
            s3_reg.req        <= req2_reg;
            s3_reg.angle      <= angle2_reg;
            s3_reg.first      <= first2_reg;
            s3_reg.elapsed_nz <= nz2_reg;
            s3_reg.big        <= big2_reg;
            s3_reg.step       <= quot_prod[RECIP_SH+STEP_W-1:RECIP_SH];
        end
    end

endmodule

`default_nettype wire

@@ hdl/ssrl_core.sv @@
// Position state update and result register.
`timescale 1ns / 1ps
`default_nettype none

module ssrl_core
    import ssrl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  cfg_t        regs,
    input  wire logic   s3_valid,
    input  step_t       s3,
    output logic        up_ready,
    ssrl_res_if.source  res
);

    logic               ovalid_reg;
    logic [ANGLE_W-1:0] cur_reg;
    logic [ANGLE_W-1:0] cur_next;
    logic [ANGLE_W-1:0] tgt_reg;
    logic [ANGLE_W-1:0] tgt_next;
    logic               wr_reg;
    logic               wr_next;
    logic [DEG_W-1:0]   deg_reg;
    logic [ANGLE_W:0]   deg_sum;
    logic               take;
    logic [ANGLE_W-1:0] lo;
    logic [ANGLE_W-1:0] hi;
    logic               up;
    logic [ANGLE_W-1:0] gap;
    logic               hit;
    logic [ANGLE_W-1:0] moved;

    function automatic logic [ANGLE_W-1:0] clamp(
        input logic [ANGLE_W-1:0] a,
        input logic [ANGLE_W-1:0] l,
        input logic [ANGLE_W-1:0] h
    );
        logic [ANGLE_W-1:0] r;
        r = a;
        if (a < l)
        begin
            r = l;
        end
        else if (a > h)
        begin
            r = h;
        end
        return r;
    endfunction

    assign take     = !ovalid_reg || res.ready;
    assign up_ready = take;

    assign lo    = (regs.min_angle < regs.max_angle) ? regs.min_angle : regs.max_angle;
    assign hi    = (regs.min_angle < regs.max_angle) ? regs.max_angle : regs.min_angle;
    assign up    = tgt_reg > cur_reg;
    assign gap   = up ? (tgt_reg - cur_reg) : (cur_reg - tgt_reg);
    assign hit   = s3.big || ({1'b0, gap} <= s3.step);
    assign moved = up ? (cur_reg + s3.step[ANGLE_W-1:0]) : (cur_reg - s3.step[ANGLE_W-1:0]);

    always_comb
    begin
        cur_next = cur_reg;
        tgt_next = tgt_reg;
        wr_next  = 1'b0;
        unique case (s3.req)
            REQ_SET_TARGET:
                tgt_next = clamp(s3.angle, lo, hi);
            REQ_SET_IMMEDIATE, REQ_RESTART:
            begin
                cur_next = clamp((s3.req == REQ_SET_IMMEDIATE) ? s3.angle : regs.initial_angle,
                                 lo, hi);
                tgt_next = cur_next;
                wr_next  = 1'b1;
            end
            REQ_TICK:
            begin
                if (!s3.first && s3.elapsed_nz)
                begin
                    if (gap <= ANGLE_W'(regs.angle_epsilon))
                    begin
                        cur_next = tgt_reg;
                    end
                    else if (s3.big || (s3.step != '0))
                    begin
                        cur_next = clamp(hit ? tgt_reg : moved, lo, hi);
                        wr_next  = 1'b1;
                    end
                end
            end
            default:
                cur_next = cur_reg;
        endcase
    end

    assign deg_sum = {1'b0, cur_next} + (ANGLE_W+1)'(128);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            cur_reg    <= RST_POSITION;
            tgt_reg    <= RST_POSITION;
        end
        else if (take)
        begin
            ovalid_reg <= s3_valid;
            if (s3_valid)
            begin
                cur_reg <= cur_next;
                tgt_reg <= tgt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s3_valid)
        begin
            wr_reg  <= wr_next;
            deg_reg <= deg_sum[ANGLE_W:ANGLE_W-DEG_W+1];
        end
    end

    assign res.valid         = ovalid_reg;
    assign res.write_valid   = wr_reg;
    assign res.servo_degrees = deg_reg;
    assign res.current_angle = cur_reg;
    assign res.target_angle  = tgt_reg;

endmodule

`default_nettype wire

@@ hdl/servo_slew_rate_limiter.sv @@
// Top level of the servo slew rate limiter.
//
//   channel  dir  beat contents
//   cmd      in   req_type, angle, now_ms
//   res      out  write_valid, servo_degrees, current_angle, target_angle
//   cfg      in   index, data (register write, always ready)
//
// Four register stages: input, rate product, step quotient, result.
// One command per cycle sustained while the result side is ready.
// The result stage holds the angle state; stalls back up stage by stage.
// Reset loads register defaults and the clamped initial angle.
`timescale 1ns / 1ps
`default_nettype none

module servo_slew_rate_limiter
    import ssrl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssrl_cmd_if.sink    cmd,
    ssrl_res_if.source  res,
    ssrl_cfg_if.sink    cfg
);

    cfg_t   regs;
    logic   s1_valid;
    front_t s1;
    logic   s2_ready;
    logic   s3_valid;
    step_t  s3;
    logic   core_ready;

    ssrl_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ssrl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .down_ready (s2_ready),
        .s1_valid   (s1_valid),
        .s1         (s1)
    );

    ssrl_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_rate   (regs.max_rate),
        .s1_valid   (s1_valid),
        .s1         (s1),
        .up_ready   (s2_ready),
        .down_ready (core_ready),
        .s3_valid   (s3_valid),
        .s3         (s3)
    );

    ssrl_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs),
        .s3_valid (s3_valid),
        .s3       (s3),
        .up_ready (core_ready),
        .res      (res)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking slew rate limiter testbench: directed, register, random and backpressure traffic.
`timescale 1ns / 1ps

module tb;
    import ssrl_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS    = 40;
    localparam int HOLD_CYCLES   = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic               write_valid;
        logic [DEG_W-1:0]   servo_degrees;
        logic [ANGLE_W-1:0] current_angle;
        logic [ANGLE_W-1:0] target_angle;
    } servo_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    ssrl_cmd_if cmd ();
    ssrl_res_if res ();
    ssrl_cfg_if cfg ();

    servo_slew_rate_limiter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    cfg_t               regs;
    logic [ANGLE_W-1:0] cur_pos;
    logic [ANGLE_W-1:0] tgt_pos;
    logic [TIME_W-1:0]  last_ms;
    logic               tick_seen;
    logic [TIME_W-1:0]  clock_ms;

    servo_cmd_t servo_q[$];

    int errors         = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int idle_mix[4]    = '{0, 65, 0, 25};
    int stall_mix[4]   = '{0, 0, 65, 25};

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch %s: got %0h expected %0h at cycle %0d",
                     what, got, want, cycle_count);
    endtask

    function automatic logic [ANGLE_W-1:0] limit_angle(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] lo;
        logic [ANGLE_W-1:0] hi;
        lo = (regs.min_angle < regs.max_angle) ? regs.min_angle : regs.max_angle;
        hi = (regs.min_angle < regs.max_angle) ? regs.max_angle : regs.min_angle;
        if (a < lo)
            return lo;
        if (a > hi)
            return hi;
        return a;
    endfunction

    function automatic servo_cmd_t advance_servo(input req_e req, input logic [ANGLE_W-1:0] ang,
                                                 input logic [TIME_W-1:0] now);
        servo_cmd_t         r;
        logic               wr;
        logic               up;
        logic [ANGLE_W-1:0] gap;
        logic [TIME_W-1:0]  elapsed;
        logic [63:0]        step;
        logic [ANGLE_W:0]   deg_sum;
        wr = 1'b0;
        case (req)
            REQ_SET_TARGET:
                tgt_pos = limit_angle(ang);
            REQ_SET_IMMEDIATE, REQ_RESTART:
            begin
                cur_pos   = limit_angle(req == REQ_SET_IMMEDIATE ? ang : regs.initial_angle);
                tgt_pos   = cur_pos;
                tick_seen = 1'b0;
                wr        = 1'b1;
            end
            REQ_TICK:
            begin
                if (!tick_seen)
                begin
                    last_ms   = now;
                    tick_seen = 1'b1;
                end
                else
                begin
                    elapsed = now - last_ms;
                    last_ms = now;
                    if (elapsed != 0)
                    begin
                        up  = tgt_pos > cur_pos;
                        gap = up ? tgt_pos - cur_pos : cur_pos - tgt_pos;
                        if (gap <= ANGLE_W'(regs.angle_epsilon))
                            cur_pos = tgt_pos;
                        else
                        begin
                            step = (64'(regs.max_rate) * 64'(elapsed)) / 64'd1000;
                            if (step != 0)
                            begin
                                if (64'(gap) <= step)
                                    cur_pos = tgt_pos;
                                else if (up)
                                    cur_pos = cur_pos + step[ANGLE_W-1:0];
                                else
                                    cur_pos = cur_pos - step[ANGLE_W-1:0];
                                cur_pos = limit_angle(cur_pos);
                                wr      = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        deg_sum           = {1'b0, cur_pos} + 17'd128;
        r.write_valid     = wr;
        r.servo_degrees   = deg_sum[ANGLE_W:8];
        r.current_angle   = cur_pos;
        r.target_angle    = tgt_pos;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        servo_cmd_t want;
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            if (servo_q.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                want = servo_q.pop_front();
                if (res.write_valid !== want.write_valid)
                    report_mismatch("write_valid", 32'(res.write_valid),
                                    32'(want.write_valid));
                if (res.servo_degrees !== want.servo_degrees)
                    report_mismatch("servo_degrees", 32'(res.servo_degrees),
                                    32'(want.servo_degrees));
                if (res.current_angle !== want.current_angle)
                    report_mismatch("current_angle", 32'(res.current_angle),
                                    32'(want.current_angle));
                if (res.target_angle !== want.target_angle)
                    report_mismatch("target_angle", 32'(res.target_angle),
                                    32'(want.target_angle));
            end
        end
    end

    // hold off for a requested stretch, else stall at random
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_cmd(input req_e req, input logic [ANGLE_W-1:0] ang,
                            input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.req_type <= req;
        cmd.angle    <= ang;
        cmd.now_ms   <= now;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        servo_q.push_back(advance_servo(req, ang, now));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        case (idx)
            CFG_MIN_ANGLE:     regs.min_angle     = data[ANGLE_W-1:0];
            CFG_MAX_ANGLE:     regs.max_angle     = data[ANGLE_W-1:0];
            CFG_INITIAL_ANGLE: regs.initial_angle = data[ANGLE_W-1:0];
            CFG_MAX_RATE:      regs.max_rate      = data[RATE_W-1:0];
            CFG_ANGLE_EPSILON: regs.angle_epsilon = data[EPS_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        cmd.valid <= 1'b0;
        while (servo_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // pad upper data bits with junk so register masking is exercised
    task automatic apply_settings(input logic [ANGLE_W-1:0] min_a, input logic [ANGLE_W-1:0] max_a,
                                  input logic [ANGLE_W-1:0] init_a, input logic [RATE_W-1:0] rate,
                                  input logic [EPS_W-1:0] eps);
        logic [7:0]  junk8;
        logic [15:0] junk16;
        wait_idle();
        junk8  = 8'($urandom);
        junk16 = 16'($urandom);
        write_reg(CFG_MIN_ANGLE, {junk8, min_a});
        write_reg(CFG_MAX_ANGLE, {junk16[7:0], max_a});
        write_reg(CFG_INITIAL_ANGLE, {junk16[15:8], init_a});
        write_reg(CFG_MAX_RATE, rate);
        write_reg(CFG_ANGLE_EPSILON, {junk16, eps});
    endtask

    task automatic randomize_settings();
        logic [ANGLE_W-1:0] a;
        logic [ANGLE_W-1:0] b;
        logic [RATE_W-1:0]  rate;
        logic [EPS_W-1:0]   eps;
        a = ANGLE_W'($urandom_range(0, 20000));
        b = ANGLE_W'($urandom_range(30000, 65535));
        case ($urandom_range(0, 3))
            0:       rate = RATE_W'($urandom_range(1, 999));
            1:       rate = RATE_W'($urandom_range(1000, 40000));
            2:       rate = RATE_W'($urandom_range(40000, 2000000));
            default: rate = RATE_W'($urandom);
        endcase
        eps = $urandom_range(0, 1) ? EPS_W'($urandom_range(0, 255))
                                   : EPS_W'($urandom_range(0, 6));
        if ($urandom_range(0, 1))
            apply_settings(b, a, ANGLE_W'($urandom), rate, eps);
        else
            apply_settings(a, b, ANGLE_W'($urandom), rate, eps);
    endtask

    task automatic run_random(input int n);
        int                 pick;
        logic [ANGLE_W-1:0] ang;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            ang  = ANGLE_W'($urandom);
            if (pick < 40)
            begin
                clock_ms = clock_ms + $urandom_range(0, 40);
                send_cmd(REQ_TICK, ang, clock_ms);
            end
            else if (pick < 48)
            begin
                clock_ms = clock_ms + $urandom_range(100, 100000);
                send_cmd(REQ_TICK, ang, clock_ms);
            end
            else if (pick < 53)
            begin
                clock_ms = $urandom_range(0, 1) ? 32'($urandom) :
                           32'hFFFF_FF00 + $urandom_range(0, 255);
                send_cmd(REQ_TICK, ang, clock_ms);
            end
            else if (pick < 70)
                send_cmd(REQ_SET_TARGET, ang, $urandom);
            else if (pick < 78)
                send_cmd(REQ_SET_TARGET, cur_pos + 16'($urandom_range(0, 16)) - 16'd8, $urandom);
            else if (pick < 88)
                send_cmd(REQ_SET_IMMEDIATE, ang, $urandom);
            else if (pick < 93)
                send_cmd(REQ_RESTART, ang, $urandom);
            else
                send_cmd(req_e'($urandom_range(0, 3)), ang, $urandom);
        end
    endtask

    task automatic test_directed_cases();
        send_cmd(REQ_TICK, 16'h0000, 32'd1000);
        send_cmd(REQ_TICK, 16'hFFFF, 32'd1000);
        send_cmd(REQ_SET_TARGET, 16'hFFFF, 32'd0);
        send_cmd(REQ_TICK, 16'h0000, 32'd1001);
        send_cmd(REQ_SET_IMMEDIATE, 16'h0000, 32'hFFFF_FFFF);
        send_cmd(REQ_SET_TARGET, 16'd46080, 32'd0);
        send_cmd(REQ_TICK, 16'h0000, 32'hFFFF_FFF0);
        send_cmd(REQ_TICK, 16'h0000, 32'h0000_0010);
        send_cmd(REQ_TICK, 16'h0000, 32'h0010_0000);
        send_cmd(REQ_SET_TARGET, 16'd46078, 32'd0);
        send_cmd(REQ_TICK, 16'hFFFF, 32'h0010_0005);
        send_cmd(REQ_RESTART, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(REQ_SET_IMMEDIATE, 16'hFFFF, 32'd0);
        send_cmd(REQ_TICK, 16'h0000, 32'd5000);
        send_cmd(REQ_SET_TARGET, 16'h0000, 32'hFFFF_FFFF);
        send_cmd(REQ_TICK, 16'h0000, 32'd5001);
        send_cmd(REQ_TICK, 16'h0000, 32'hFFFF_FFFF);
        send_cmd(REQ_TICK, 16'hFFFF, 32'd0);
        clock_ms = 32'd0;
    endtask

    task automatic test_register_settings();
        apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 8'd0);
        send_cmd(REQ_RESTART, 16'd0, 32'd0);
        run_random(30);
        apply_settings(16'd40000, 16'd10000, 16'd0, 24'd0, 8'hFF);
        send_cmd(REQ_RESTART, 16'd0, 32'd0);
        run_random(30);
        apply_settings(16'd30000, 16'd30000, 16'hFFFF, 24'd999, 8'd0);
        run_random(30);
        apply_settings(16'd100, 16'd200, 16'd150, 24'd1, 8'd1);
        for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++)
            write_reg(i[CFG_IDX_W-1:0], CFG_DAT_W'($urandom));
        run_random(30);
        apply_settings(RST_MIN_ANGLE, RST_MAX_ANGLE, RST_INITIAL_ANGLE, RST_MAX_RATE,
                       RST_ANGLE_EPSILON);
        run_random(30);
    endtask

    task automatic test_random_traffic();
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct  = idle_mix[m];
            recv_stall_pct = stall_mix[m];
            repeat (2)
            begin
                randomize_settings();
                run_random(180);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // hold the result side so the pipeline fills and stalls its input
    task automatic test_backpressure();
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = HOLD_CYCLES;
        run_random(40);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cmd.valid          = 1'b0;
        cmd.req_type       = REQ_SET_TARGET;
        cmd.angle          = '0;
        cmd.now_ms         = '0;
        res.ready          = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = CFG_MIN_ANGLE;
        cfg.data           = '0;
        regs.min_angle     = RST_MIN_ANGLE;
        regs.max_angle     = RST_MAX_ANGLE;
        regs.initial_angle = RST_INITIAL_ANGLE;
        regs.max_rate      = RST_MAX_RATE;
        regs.angle_epsilon = RST_ANGLE_EPSILON;
        cur_pos            = RST_POSITION;
        tgt_pos            = RST_POSITION;
        last_ms            = '0;
        tick_seen          = 1'b0;
        clock_ms           = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_register_settings();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        if (errors == 0 && servo_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
